// File: rtl/core/sine_palette_color_map_macros.svh
// Assertion macros shared by the color map RTL.
// Depends on nothing; included by the files that carry concurrent checks.
`ifndef SINE_PALETTE_COLOR_MAP_MACROS_SVH
`define SINE_PALETTE_COLOR_MAP_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define SPCM_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define SPCM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/spcm_pkg.sv
// Shared types, constants and the quarter-wave sine table of the color map.
// Depends on nothing; used by spcm_channel and sine_palette_color_map.
package spcm_pkg;

    // Sizing
    localparam int SINE_TABLE_DEPTH   = 256;
    localparam int ITER_FRACTION_BITS = 8;
    localparam int COUNT_W    = 24;
    localparam int REG_W      = 16;
    localparam int CENTER_W   = 8;
    localparam int CHAN_W     = 8;
    localparam int RGB_W      = 3 * CHAN_W;
    localparam int SINE_MAG_W = 8;
    localparam int NUM_STAGES = 9;

    // Configuration port
    localparam int REG_COUNT  = 8;
    localparam int CFG_ADDR_W = $clog2(REG_COUNT) + 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [$clog2(REG_COUNT)-1:0] {
        CFG_ITER_LIMIT   = 0,
        CFG_RED_FREQ     = 1,
        CFG_GREEN_FREQ   = 2,
        CFG_BLUE_FREQ    = 3,
        CFG_RED_PHASE    = 4,
        CFG_GREEN_PHASE  = 5,
        CFG_BLUE_PHASE   = 6,
        CFG_COLOR_CENTER = 7
    } spcm_cfg_reg_t;

    localparam logic [REG_W-1:0]    RST_ITER_LIMIT   = 16'd50;
    localparam logic [REG_W-1:0]    RST_FREQ         = 16'd1352;
    localparam logic [REG_W-1:0]    RST_RED_PHASE    = 16'd0;
    localparam logic [REG_W-1:0]    RST_GREEN_PHASE  = 16'd4289;
    localparam logic [REG_W-1:0]    RST_BLUE_PHASE   = 16'd8579;
    localparam logic [CENTER_W-1:0] RST_COLOR_CENTER = 8'd127;

    // Limit compare: count against limit scaled to the count's fraction
    localparam int LIMIT_SH_W = REG_W + ITER_FRACTION_BITS;
    localparam int CMP_W      = (COUNT_W > LIMIT_SH_W) ? COUNT_W : LIMIT_SH_W;

    // Angle arithmetic: 2*pi at the angle's scale, 12+F fraction bits
    localparam longint unsigned TWO_PI_Q32   = 64'd26986075409;
    localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
    localparam longint unsigned AMPLITUDE    = 64'd128;
    localparam int              TWO_PI_SHIFT = 20 - ITER_FRACTION_BITS;
    localparam longint unsigned TWO_PI_FIX   =
        (TWO_PI_Q32 + (64'd1 << (TWO_PI_SHIFT - 1))) >> TWO_PI_SHIFT;

    localparam int P_W         = 15 + ITER_FRACTION_BITS;
    localparam int REM_W       = P_W + 1;
    localparam int ANGLE_W     = REG_W + COUNT_W + 1;
    localparam int PHASE_SHIFT = ITER_FRACTION_BITS + 1;

    // Quotient estimate from the top angle bits; never high, at most one low
    localparam int HI_SHIFT    = P_W - 3;
    localparam int HI_W        = ANGLE_W - HI_SHIFT;
    localparam int QUO_SHIFT   = HI_W + 3;
    localparam int QUO_W       = ANGLE_W - P_W + 1;
    localparam int QUO_RECIP_W = ANGLE_W + 4 - P_W;
    localparam longint unsigned QUO_RECIP =
        (64'd1 << (HI_SHIFT + QUO_SHIFT)) / TWO_PI_FIX;

    // Table index estimate: floor(a * 4D / 2pi), at most one low
    localparam int ADDR_W      = $clog2(SINE_TABLE_DEPTH);
    localparam int IDX_W       = ADDR_W + 2;
    localparam int IDX_RECIP_W = IDX_W + 1;
    localparam longint unsigned IDX_RECIP = (64'd1 << (IDX_W + P_W)) / TWO_PI_FIX;

    localparam logic [P_W-1:0]         TWO_PI_K    = P_W'(TWO_PI_FIX);
    localparam logic [REM_W-1:0]       TWO_PI_REM  = REM_W'(TWO_PI_FIX);
    localparam logic [REM_W-1:0]       TWO_PI_DBL  = REM_W'(2 * TWO_PI_FIX);
    localparam logic [QUO_RECIP_W-1:0] QUO_RECIP_K = QUO_RECIP_W'(QUO_RECIP);
    localparam logic [IDX_RECIP_W-1:0] IDX_RECIP_K = IDX_RECIP_W'(IDX_RECIP);

    // Pipeline control handed to each channel
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic                  blank;
    } spcm_pipe_ctrl_t;

    // round(128*sin(j*pi/(2D))) through a truncated Q30 Taylor series
    function automatic logic [SINE_MAG_W-1:0] quarter_sine(input longint unsigned j);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned rounded;
        longint          sum;
        x    = (HALF_PI_Q30 * j) / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 156;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 210;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 272;
        sum  = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        rounded = ((unsigned'(sum) * AMPLITUDE) + (64'd1 << 29)) >> 30;
        return SINE_MAG_W'(rounded);
    endfunction

    function automatic logic [SINE_TABLE_DEPTH*SINE_MAG_W-1:0] build_sine_rom();
        logic [SINE_TABLE_DEPTH*SINE_MAG_W-1:0] rom;
        rom = '0;
        for (int j = 0; j < SINE_TABLE_DEPTH; j++) begin
            rom[j*SINE_MAG_W +: SINE_MAG_W] = quarter_sine(64'(j));
        end
        return rom;
    endfunction

    // Entries 0..D-1; entry D (the crest) is kept apart
    localparam logic [SINE_TABLE_DEPTH*SINE_MAG_W-1:0] SINE_ROM = build_sine_rom();
    localparam logic [SINE_MAG_W-1:0] SINE_PEAK = quarter_sine(64'(SINE_TABLE_DEPTH));

endpackage

// File: rtl/core/spcm_channel.sv
// One color channel datapath: angle, mod-2pi reduction, table index, sine, clamp.
// Depends on spcm_pkg and sine_palette_color_map_macros.svh.
`include "sine_palette_color_map_macros.svh"

module spcm_channel (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  spcm_pkg::spcm_pipe_ctrl_t          ctrl,
    input  logic [spcm_pkg::COUNT_W-1:0]       count,
    input  logic [spcm_pkg::REG_W-1:0]         freq,
    input  logic [spcm_pkg::REG_W-1:0]         phase,
    input  logic [spcm_pkg::CENTER_W-1:0]      center,
    output logic [spcm_pkg::CHAN_W-1:0]        chan_value
);

    // stage 0: angle = freq * count + phase, phase aligned to 12+F fraction bits
    logic [spcm_pkg::REG_W+spcm_pkg::COUNT_W-1:0] step_prod;
    logic [spcm_pkg::ANGLE_W-1:0]                 angle_reg, angle_next;

    assign step_prod  = freq * count;
    assign angle_next = spcm_pkg::ANGLE_W'(step_prod)
                      + (spcm_pkg::ANGLE_W'(phase) << spcm_pkg::PHASE_SHIFT);

    // stage 1: quotient estimate by reciprocal of 2pi
    logic [spcm_pkg::HI_W+spcm_pkg::QUO_RECIP_W-1:0] quo_prod;
    logic [spcm_pkg::QUO_W-1:0]                      quo_reg, quo_next;
    logic [spcm_pkg::REM_W-1:0]                      angle_lo_reg, angle_lo_next;

    assign quo_prod      = angle_reg[spcm_pkg::ANGLE_W-1:spcm_pkg::HI_SHIFT]
                         * spcm_pkg::QUO_RECIP_K;
    assign quo_next      = quo_prod[spcm_pkg::QUO_SHIFT +: spcm_pkg::QUO_W];
    assign angle_lo_next = angle_reg[spcm_pkg::REM_W-1:0];

    // stage 2: partial remainder, below 2*2pi so the low bits suffice
    logic [spcm_pkg::QUO_W+spcm_pkg::P_W-1:0] back_prod;
    logic [spcm_pkg::REM_W-1:0]               apre_reg, apre_next;

    assign back_prod = quo_reg * spcm_pkg::TWO_PI_K;
    assign apre_next = angle_lo_reg - back_prod[spcm_pkg::REM_W-1:0];

    // stage 3: final correction of the angle into 0..2pi
    logic [spcm_pkg::REM_W-1:0] apre_diff;
    logic [spcm_pkg::P_W-1:0]   wrap_reg, wrap_next;

    assign apre_diff = apre_reg - spcm_pkg::TWO_PI_REM;
    assign wrap_next = (apre_reg >= spcm_pkg::TWO_PI_REM)
                     ? apre_diff[spcm_pkg::P_W-1:0] : apre_reg[spcm_pkg::P_W-1:0];

    // stage 4: table index estimate
    logic [spcm_pkg::P_W+spcm_pkg::IDX_RECIP_W-1:0] idx_prod;
    logic [spcm_pkg::IDX_W-1:0]                     est_reg, est_next;
    logic [spcm_pkg::P_W-1:0]                       wrap4_reg, wrap4_next;

    assign idx_prod   = wrap_reg * spcm_pkg::IDX_RECIP_K;
    assign est_next   = idx_prod[spcm_pkg::P_W +: spcm_pkg::IDX_W];
    assign wrap4_next = wrap_reg;

    // stage 5: leftover of a*4D against est*2pi
    logic [spcm_pkg::P_W+spcm_pkg::IDX_W-1:0] wrap_scaled;
    logic [spcm_pkg::IDX_W+spcm_pkg::P_W-1:0] est_prod;
    logic [spcm_pkg::REM_W-1:0]               rem_reg, rem_next;
    logic [spcm_pkg::IDX_W-1:0]               est5_reg, est5_next;

    assign wrap_scaled = (spcm_pkg::P_W + spcm_pkg::IDX_W)'(wrap4_reg) << spcm_pkg::IDX_W;
    assign est_prod    = est_reg * spcm_pkg::TWO_PI_K;
    assign rem_next    = wrap_scaled[spcm_pkg::REM_W-1:0] - est_prod[spcm_pkg::REM_W-1:0];
    assign est5_next   = est_reg;

    // stage 6: exact index, quadrant folding into a table address
    logic [spcm_pkg::IDX_W-1:0]  idx;
    logic [1:0]                  quadrant;
    logic [spcm_pkg::ADDR_W-1:0] offset;
    logic [spcm_pkg::ADDR_W-1:0] offset_neg;
    logic [spcm_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic                        peak_reg, peak_next;
    logic                        neg6_reg, neg6_next;

    assign idx        = est5_reg + spcm_pkg::IDX_W'(rem_reg >= spcm_pkg::TWO_PI_REM);
    assign quadrant   = idx[spcm_pkg::IDX_W-1 -: 2];
    assign offset     = idx[spcm_pkg::ADDR_W-1:0];
    assign offset_neg = {spcm_pkg::ADDR_W{1'b0}} - offset;
    // odd quadrants read the table backwards; offset zero there is the crest
    assign peak_next  = quadrant[0] && (offset == '0);
    assign addr_next  = quadrant[0] ? offset_neg : offset;
    assign neg6_next  = quadrant[1];

    // stage 7: table read
    logic [spcm_pkg::SINE_MAG_W-1:0] mag_reg, mag_next;
    logic                            neg7_reg, neg7_next;

    assign mag_next  = peak_reg ? spcm_pkg::SINE_PEAK
                     : spcm_pkg::SINE_ROM[addr_reg*spcm_pkg::SINE_MAG_W +: spcm_pkg::SINE_MAG_W];
    assign neg7_next = neg6_reg;

    // stage 8: center plus signed sine, clamped to 0..255, black when blanked
    logic [spcm_pkg::CHAN_W+1:0] level;
    logic [spcm_pkg::CHAN_W-1:0] clamped;
    logic [spcm_pkg::CHAN_W-1:0] chan_reg, chan_next;

    always_comb begin
        if (neg7_reg) begin
            level = (spcm_pkg::CHAN_W + 2)'(center) - (spcm_pkg::CHAN_W + 2)'(mag_reg);
        end else begin
            level = (spcm_pkg::CHAN_W + 2)'(center) + (spcm_pkg::CHAN_W + 2)'(mag_reg);
        end
        if (level[spcm_pkg::CHAN_W+1]) begin
            clamped = '0;
        end else if (level[spcm_pkg::CHAN_W]) begin
            clamped = '1;
        end else begin
            clamped = level[spcm_pkg::CHAN_W-1:0];
        end
        chan_next = ctrl.blank ? '0 : clamped;
    end

    // stage registers, each loaded when its beat moves in
    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            angle_reg <= angle_next;
        end
        if (ctrl.load[1]) begin
            quo_reg      <= quo_next;
            angle_lo_reg <= angle_lo_next;
        end
        if (ctrl.load[2]) begin
            apre_reg <= apre_next;
        end
        if (ctrl.load[3]) begin
            wrap_reg <= wrap_next;
        end
        if (ctrl.load[4]) begin
            est_reg   <= est_next;
            wrap4_reg <= wrap4_next;
        end
        if (ctrl.load[5]) begin
            rem_reg  <= rem_next;
            est5_reg <= est5_next;
        end
        if (ctrl.load[6]) begin
            addr_reg <= addr_next;
            peak_reg <= peak_next;
            neg6_reg <= neg6_next;
        end
        if (ctrl.load[7]) begin
            mag_reg  <= mag_next;
            neg7_reg <= neg7_next;
        end
        if (ctrl.load[8]) begin
            chan_reg <= chan_next;
        end
    end

    assign chan_value = chan_reg;

    // reciprocal estimates must leave at most one correction step
    `SPCM_ASSERT_IMPLY(a_apre_range, aclk, aresetn, $past(ctrl.load[2]), apre_reg < spcm_pkg::TWO_PI_DBL, "partial angle remainder not below twice 2pi")
    `SPCM_ASSERT_IMPLY(a_wrap_range, aclk, aresetn, $past(ctrl.load[3]), wrap_reg < spcm_pkg::TWO_PI_K, "reduced angle not below 2pi")
    `SPCM_ASSERT_IMPLY(a_rem_range, aclk, aresetn, $past(ctrl.load[5]), rem_reg < spcm_pkg::TWO_PI_DBL, "index estimate off by more than one")

endmodule

// File: rtl/core/sine_palette_color_map.sv
// Sine-wave rainbow palette: iteration count in, packed RGB color out.
// Holds the register file, the pipeline valid chain and three spcm_channel datapaths.
// Depends on spcm_pkg, spcm_channel and sine_palette_color_map_macros.svh.
//
// Each beat carries one unsigned Q16.8 iteration count and yields one 24-bit color
// (red 23:16, green 15:8, blue 7:0). The datapath is a nine-stage pipeline: a new
// count is taken every cycle while s_ready is high, and its color leaves from the last
// stage. Every stage advances on its own, so bubbles close up under output
// backpressure and s_ready drops only when all nine stages are full and m_ready is
// low. A count at or above iteration_limit (scaled by 256) gives black. The eight
// registers sit on the APB port at byte addresses 0, 4, ... 28; change them only
// while no beat is in flight.
`include "sine_palette_color_map_macros.svh"

module sine_palette_color_map (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [spcm_pkg::COUNT_W-1:0]        s_iteration_count,
    // result stream
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [spcm_pkg::RGB_W-1:0]          m_rgb_color,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [spcm_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [spcm_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [spcm_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    // register file
    logic [spcm_pkg::REG_W-1:0]    iter_limit_reg;
    logic [spcm_pkg::REG_W-1:0]    red_freq_reg, green_freq_reg, blue_freq_reg;
    logic [spcm_pkg::REG_W-1:0]    red_phase_reg, green_phase_reg, blue_phase_reg;
    logic [spcm_pkg::CENTER_W-1:0] center_reg;
    spcm_pkg::spcm_cfg_reg_t       cfg_sel;
    logic                          cfg_write;

    assign pready    = 1'b1;
    assign cfg_sel   = spcm_pkg::spcm_cfg_reg_t'(paddr[spcm_pkg::CFG_ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iter_limit_reg  <= spcm_pkg::RST_ITER_LIMIT;
            red_freq_reg    <= spcm_pkg::RST_FREQ;
            green_freq_reg  <= spcm_pkg::RST_FREQ;
            blue_freq_reg   <= spcm_pkg::RST_FREQ;
            red_phase_reg   <= spcm_pkg::RST_RED_PHASE;
            green_phase_reg <= spcm_pkg::RST_GREEN_PHASE;
            blue_phase_reg  <= spcm_pkg::RST_BLUE_PHASE;
            center_reg      <= spcm_pkg::RST_COLOR_CENTER;
        end else if (cfg_write) begin
            case (cfg_sel)
                spcm_pkg::CFG_ITER_LIMIT:   iter_limit_reg  <= pwdata[spcm_pkg::REG_W-1:0];
                spcm_pkg::CFG_RED_FREQ:     red_freq_reg    <= pwdata[spcm_pkg::REG_W-1:0];
                spcm_pkg::CFG_GREEN_FREQ:   green_freq_reg  <= pwdata[spcm_pkg::REG_W-1:0];
                spcm_pkg::CFG_BLUE_FREQ:    blue_freq_reg   <= pwdata[spcm_pkg::REG_W-1:0];
                spcm_pkg::CFG_RED_PHASE:    red_phase_reg   <= pwdata[spcm_pkg::REG_W-1:0];
                spcm_pkg::CFG_GREEN_PHASE:  green_phase_reg <= pwdata[spcm_pkg::REG_W-1:0];
                spcm_pkg::CFG_BLUE_PHASE:   blue_phase_reg  <= pwdata[spcm_pkg::REG_W-1:0];
                spcm_pkg::CFG_COLOR_CENTER: center_reg      <= pwdata[spcm_pkg::CENTER_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (cfg_sel)
            spcm_pkg::CFG_ITER_LIMIT:   prdata = spcm_pkg::CFG_DATA_W'(iter_limit_reg);
            spcm_pkg::CFG_RED_FREQ:     prdata = spcm_pkg::CFG_DATA_W'(red_freq_reg);
            spcm_pkg::CFG_GREEN_FREQ:   prdata = spcm_pkg::CFG_DATA_W'(green_freq_reg);
            spcm_pkg::CFG_BLUE_FREQ:    prdata = spcm_pkg::CFG_DATA_W'(blue_freq_reg);
            spcm_pkg::CFG_RED_PHASE:    prdata = spcm_pkg::CFG_DATA_W'(red_phase_reg);
            spcm_pkg::CFG_GREEN_PHASE:  prdata = spcm_pkg::CFG_DATA_W'(green_phase_reg);
            spcm_pkg::CFG_BLUE_PHASE:   prdata = spcm_pkg::CFG_DATA_W'(blue_phase_reg);
            spcm_pkg::CFG_COLOR_CENTER: prdata = spcm_pkg::CFG_DATA_W'(center_reg);
            default:                    prdata = '0;
        endcase
    end

    // pipeline flow control: a stage takes a beat when empty or when it drains
    logic [spcm_pkg::NUM_STAGES-1:0] valid_reg, valid_next;
    logic [spcm_pkg::NUM_STAGES-1:0] black_reg, black_next;
    logic [spcm_pkg::NUM_STAGES:0]   stage_ready;
    logic [spcm_pkg::NUM_STAGES-1:0] stage_in_valid;
    logic [spcm_pkg::NUM_STAGES-1:0] stage_load;
    logic                            black_in;
    logic                            in_fire, out_fire;
    spcm_pkg::spcm_pipe_ctrl_t       pipe_ctrl;

    always_comb begin
        stage_ready[spcm_pkg::NUM_STAGES] = m_ready;
        for (int i = spcm_pkg::NUM_STAGES - 1; i >= 0; i--) begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
    end

    assign stage_in_valid = {valid_reg[spcm_pkg::NUM_STAGES-2:0], s_valid};
    assign stage_load     = stage_ready[spcm_pkg::NUM_STAGES-1:0] & stage_in_valid;

    always_comb begin
        for (int i = 0; i < spcm_pkg::NUM_STAGES; i++) begin
            valid_next[i] = stage_ready[i] ? stage_in_valid[i] : valid_reg[i];
        end
    end

    // limit check travels beside the datapath as a black flag
    assign black_in   = spcm_pkg::CMP_W'(s_iteration_count)
                     >= (spcm_pkg::CMP_W'(iter_limit_reg) << spcm_pkg::ITER_FRACTION_BITS);
    assign black_next = {black_reg[spcm_pkg::NUM_STAGES-2:0], black_in};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < spcm_pkg::NUM_STAGES; i++) begin
            if (stage_load[i]) begin
                black_reg[i] <= black_next[i];
            end
        end
    end

    assign pipe_ctrl.load  = stage_load;
    assign pipe_ctrl.blank = black_reg[spcm_pkg::NUM_STAGES-2];

    // channel datapaths
    logic [spcm_pkg::CHAN_W-1:0] red_value, green_value, blue_value;

    spcm_channel u_red (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (pipe_ctrl),
        .count      (s_iteration_count),
        .freq       (red_freq_reg),
        .phase      (red_phase_reg),
        .center     (center_reg),
        .chan_value (red_value)
    );

    spcm_channel u_green (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (pipe_ctrl),
        .count      (s_iteration_count),
        .freq       (green_freq_reg),
        .phase      (green_phase_reg),
        .center     (center_reg),
        .chan_value (green_value)
    );

    spcm_channel u_blue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (pipe_ctrl),
        .count      (s_iteration_count),
        .freq       (blue_freq_reg),
        .phase      (blue_phase_reg),
        .center     (center_reg),
        .chan_value (blue_value)
    );

    // outputs
    assign s_ready     = stage_ready[0];
    assign m_valid     = valid_reg[spcm_pkg::NUM_STAGES-1];
    assign m_rgb_color = {red_value, green_value, blue_value};
    assign in_fire     = s_valid && s_ready;
    assign out_fire    = m_valid && m_ready;

    // beats in flight change only by what enters and what leaves
    `SPCM_ASSERT_IMPLY(a_occupancy, aclk, aresetn, $past(aresetn), $countones(valid_reg) == $countones($past(valid_reg)) + int'($past(in_fire)) - int'($past(out_fire)), "beat lost or duplicated in pipeline")
    // a full pipeline with a held output must not take more input
    `SPCM_ASSERT_IMPLY(a_full_blocks, aclk, aresetn, (&valid_reg) && !m_ready, !s_ready, "input taken while pipeline full and stalled")
    // limit-reached beats leave as black
    `SPCM_ASSERT_IMPLY(a_black_out, aclk, aresetn, m_valid && black_reg[spcm_pkg::NUM_STAGES-1], m_rgb_color == '0, "limit-reached beat not black")

endmodule
